// File: rtl/cobs_stream_deframer_defines.svh
// Assertion macros shared by the COBS stream deframer RTL.
// Stand-alone header; the top level includes it by file name.
`ifndef COBS_STREAM_DEFRAMER_DEFINES_SVH
`define COBS_STREAM_DEFRAMER_DEFINES_SVH

// Checks that the antecedent implies the consequent in the same cycle, outside reset.
`define CSD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cobs_stream_deframer: same-cycle check failed");

// Checks that the antecedent implies the consequent in the next cycle, reset included.
`define CSD_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cobs_stream_deframer: next-cycle check failed");

`endif

// File: rtl/csd_pkg.sv
// Types and constants of the COBS stream deframer.
// Used by the top level, the decode and the result register; depends on nothing.
package csd_pkg;

   localparam int unsigned CNT_W = 13;
   localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;
   localparam logic [7:0] CODE_FULL = 8'hFF;

   typedef enum logic [1:0] {
      STATUS_GOOD      = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_TOO_LONG  = 2'd3
   } frame_status_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             is_end;
      frame_status_type frame_status;
   } result_type;

   typedef struct packed {
      logic             hunting;
      logic             first_code;
      logic [7:0]       bytes_left;
      logic             last_code_full;
      logic [CNT_W-1:0] raw_count;
      logic [CNT_W-1:0] decoded_count;
   } state_type;

endpackage

// File: rtl/cobs_stream_deframer.sv
// COBS stream deframer: takes one link byte per request and returns decoded payload bytes
// and one end record with status per frame. It sustains one request per clock cycle while
// the response channel is not stalled; a byte passes an input register and then a result
// register before its result is offered. The per-byte decode is a combinational update
// of the frame state between those two registers, and that update sets the rate. The
// length limit is written through the csr port, which is always ready.
module cobs_stream_deframer #(
   parameter int unsigned MAX_LEN = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_end,
   output logic [1:0]  rsp_frame_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_max_frame_len
);

   `include "cobs_stream_deframer_defines.svh"

   localparam logic [12:0] LIMIT_RESET =
      (MAX_LEN > 8191) ? csd_pkg::CNT_MAX : 13'(MAX_LEN);

   logic                in_valid;
   logic [7:0]          in_byte;
   logic                out_ready;
   logic                advance;
   logic                has_result;
   csd_pkg::result_type result;
   csd_pkg::result_type rsp_result;
   csd_pkg::state_type  state;

   assign csr_ready = 1'b1;
   assign advance   = in_valid && out_ready;

   csd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   csd_decode #(
      .LIMIT_RESET (LIMIT_RESET)
   ) u_decode (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_valid && csr_ready),
      .csr_max_frame_len (csr_max_frame_len),
      .advance           (advance),
      .in_byte           (in_byte),
      .has_result        (has_result),
      .result            (result),
      .state             (state)
   );

   csd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && has_result),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_out_byte     = rsp_result.out_byte;
   assign rsp_is_end       = rsp_result.is_end;
   assign rsp_frame_status = rsp_result.frame_status;

   // A full input register facing a stalled result register must refuse new requests.
   `CSD_ASSERT_SAME(a_stall_blocks_req, clock, reset, in_valid && rsp_valid && !rsp_ready, !req_ready)
   // While hunting for a delimiter, no decoded byte or end record is produced.
   `CSD_ASSERT_SAME(a_hunt_is_silent, clock, reset, advance && state.hunting, !has_result)
   // Leaving reset, the result channel is empty and the input side is open.
   `CSD_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

// File: rtl/csd_in_stage.sv
// Input register of the COBS stream deframer: holds one received byte.
// Depends on nothing but the handshake from the top level.
module csd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

// File: rtl/csd_decode.sv
// Per-byte COBS decode: frame state, length limit register and result logic.
// Depends on csd_pkg for the state, result and status types.
module csd_decode #(
   parameter logic [12:0] LIMIT_RESET = 13'd4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [12:0]           csr_max_frame_len,
   input  logic                  advance,
   input  logic [7:0]            in_byte,
   output logic                  has_result,
   output csd_pkg::result_type   result,
   output csd_pkg::state_type    state
);

   csd_pkg::state_type state_ff, state_in;
   logic [12:0]        limit_ff;
   logic               zero_byte;
   logic               emit_zero;

   assign zero_byte = (in_byte == 8'd0);

   always_comb begin
      state_in   = state_ff;
      has_result = 1'b0;
      result     = '{out_byte: 8'd0, is_end: 1'b0,
                     frame_status: csd_pkg::STATUS_GOOD};
      emit_zero  = !state_ff.first_code && !state_ff.last_code_full;

      if (state_ff.hunting) begin
         if (zero_byte) begin
            state_in         = '0;
            state_in.first_code = 1'b1;
         end
      end else if (zero_byte) begin
         // A zero right after the delimiter is a leading zero and is skipped.
         if (state_ff.raw_count != '0) begin
            has_result    = 1'b1;
            result.is_end = 1'b1;
            if (state_ff.raw_count >= csd_pkg::CNT_MAX || state_ff.raw_count > limit_ff) begin
               result.frame_status = csd_pkg::STATUS_TOO_LONG;
            end else if (state_ff.bytes_left != 8'd0) begin
               result.frame_status = csd_pkg::STATUS_MALFORMED;
            end else if (state_ff.decoded_count == '0) begin
               result.frame_status = csd_pkg::STATUS_EMPTY;
            end else begin
               result.frame_status = csd_pkg::STATUS_GOOD;
            end
            state_in            = '0;
            state_in.hunting    = 1'b1;
            state_in.first_code = 1'b1;
         end
      end else begin
         if (state_ff.raw_count < csd_pkg::CNT_MAX) begin
            state_in.raw_count = state_ff.raw_count + 13'd1;
         end
         if (state_ff.bytes_left == 8'd0) begin
            // A code byte: the block before it ends with an implied zero
            // unless it was a full block.
            state_in.first_code     = 1'b0;
            state_in.last_code_full = (in_byte == csd_pkg::CODE_FULL);
            state_in.bytes_left     = in_byte - 8'd1;
            if (emit_zero) begin
               has_result = 1'b1;
               if (state_ff.decoded_count < csd_pkg::CNT_MAX) begin
                  state_in.decoded_count = state_ff.decoded_count + 13'd1;
               end
            end
         end else begin
            state_in.bytes_left = state_ff.bytes_left - 8'd1;
            has_result          = 1'b1;
            result.out_byte     = in_byte;
            if (state_ff.decoded_count < csd_pkg::CNT_MAX) begin
               state_in.decoded_count = state_ff.decoded_count + 13'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{hunting: 1'b1, first_code: 1'b1, bytes_left: 8'd0,
                       last_code_full: 1'b0, raw_count: '0, decoded_count: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_max_frame_len;
      end
   end

   assign state = state_ff;

endmodule

// File: rtl/csd_out_reg.sv
// Result register of the COBS stream deframer, drives the response channel.
// Depends on csd_pkg for the result type.
module csd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  csd_pkg::result_type result,
   output logic                out_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output csd_pkg::result_type rsp_result
);

   logic                valid_ff, valid_in;
   csd_pkg::result_type result_ff;

   assign out_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule
